// ===== rtl/plin_pkg.sv =====
// plin_pkg: widths, table size, state codes and bundle types for the
// piecewise linear lookup block; no dependencies
package plin_pkg;

   localparam int TABLE_POINTS = 16;
   localparam int IDX_W        = $clog2(TABLE_POINTS);
   localparam int CNT_W        = $clog2(TABLE_POINTS + 1);
   localparam int DATA_W       = 16;
   localparam int PIDX_W       = 4;
   localparam int SEG_W        = 4;
   localparam int POINTS_W     = 5;
   localparam int PROD_W       = 2 * DATA_W;
   localparam int DIV_STEPS    = PROD_W;
   localparam int STEP_W       = $clog2(DIV_STEPS);
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   localparam logic [POINTS_W-1:0] POINTS_RESET = POINTS_W'(TABLE_POINTS);

   typedef enum logic [0:0] {
      REG_POINTS_IN_USE = 1'b0
   } csr_index_type;

   typedef enum logic [0:0] {
      CMD_LOAD = 1'b0,
      CMD_EVAL = 1'b1
   } command_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_MULT   = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] y;
   } table_wr_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== rtl/plin_if.sv =====
// plin_req_if and plin_rsp_if: valid/ready channels of the lookup block
// depends on plin_pkg
interface plin_req_if
   import plin_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic                     command;
   logic [PIDX_W-1:0]        point_index;
   logic signed [DATA_W-1:0] breakpoint_x;
   logic signed [DATA_W-1:0] breakpoint_y;
   logic signed [DATA_W-1:0] sample;

   modport source (output valid, command, point_index, breakpoint_x, breakpoint_y,
                   sample, input ready);
   modport sink   (input valid, command, point_index, breakpoint_x, breakpoint_y,
                   sample, output ready);
endinterface

interface plin_rsp_if
   import plin_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] result_value;
   logic                     in_segment;
   logic [SEG_W-1:0]         segment_found;

   modport source (output valid, result_value, in_segment, segment_found, input ready);
   modport sink   (input valid, result_value, in_segment, segment_found, output ready);
endinterface

// ===== rtl/piecewise_linear_lookup_top.sv =====
// piecewise_linear_lookup_top: sequencer, scan registers and result register
// depends on plin_pkg, plin_if, plin_table, plin_div
//
// usage: items arrive on req_bus, results leave on rsp_bus; both transfer
// when valid and ready are high at a rising clock edge.
// a load item writes one breakpoint in its transfer cycle and gives no result;
// req_bus.ready stays high.
// an evaluate item reads one breakpoint a cycle from the memory read port,
// comparing each against the one before, until it finds the segment that
// holds the sample or falls back to the last point in use.
// a hit then passes a multiply state and the serial divider (one quotient
// bit a cycle); a hit or a miss ends in a finish state that writes the
// output register.
// one evaluate item is in work at a time; req_bus.ready is low meanwhile and
// the next item is taken in the cycle after the output register is written.
// the output register holds a finished result while rsp_bus.ready is low and
// a new item is already taken; a second finished result waits in its last
// state until the register frees.
// points_in_use is written over the apb port at byte addresses 0 to 3 (paddr[2] low).
// reset sets points_in_use to 16 and empties the output register; the
// breakpoint memory holds no reset value and must be loaded before use.
module piecewise_linear_lookup_top
   import plin_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   plin_req_if.sink              req_bus,
   plin_rsp_if.source            rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   state_type         state_ff, state_in;
   logic [POINTS_W-1:0] points_ff, points_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]  last_ff, last_in;
   logic [DATA_W-1:0] sample_ff, sample_in;
   logic [DATA_W-1:0] hi_x_ff, hi_x_in;
   logic [DATA_W-1:0] hi_y_ff, hi_y_in;
   logic [DATA_W-1:0] lo_y_ff, lo_y_in;
   logic [DATA_W-1:0] dx_ff, dx_in;
   logic [DATA_W-1:0] dy_mag_ff, dy_mag_in;
   logic              neg_ff, neg_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic [IDX_W-1:0]  seg_ff, seg_in;
   logic              hit_ff, hit_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [SEG_W-1:0]  rsp_seg_ff, rsp_seg_in;

   table_wr_type      tbl_wr;
   logic [IDX_W-1:0]  tbl_raddr;
   logic [DATA_W-1:0] tbl_rx;
   logic [DATA_W-1:0] tbl_ry;
   div_ctrl_type      div_ctrl;
   div_stat_type      div_stat;
   logic [PROD_W-1:0] div_quo;
   logic [PROD_W-1:0] product;

   logic              req_xfer;
   logic              csr_wr;
   logic [CNT_W-1:0]  active_n;
   logic              seg_match;
   logic [DATA_W:0]   dx_full;
   logic [DATA_W:0]   den_full;
   logic [DATA_W:0]   dy_full;
   logic [DATA_W:0]   dy_abs;
   logic [DATA_W:0]   q_signed;
   logic [DATA_W:0]   sum_full;

   plin_table u_table (
      .clock (clock),
      .wr    (tbl_wr),
      .raddr (tbl_raddr),
      .rx    (tbl_rx),
      .ry    (tbl_ry)
   );

   plin_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (product),
      .divisor  (den_ff),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   assign req_xfer = req_bus.valid && req_bus.ready;
   assign csr_wr   = psel && penable && pwrite && pready
                     && (paddr[CSR_ADDR_W-1] == REG_POINTS_IN_USE);
   assign pready   = 1'b1;
   assign prdata   = CSR_DATA_W'(points_ff);

   always_comb begin
      if (points_ff == '0) begin
         active_n = CNT_W'(1);
      end else if (int'(points_ff) > TABLE_POINTS) begin
         active_n = CNT_W'(TABLE_POINTS);
      end else begin
         active_n = CNT_W'(points_ff);
      end
   end

   assign seg_match = (rd_idx_ff != '0)
                      && ($signed(hi_x_ff) > $signed(sample_ff))
                      && ($signed(tbl_rx) <= $signed(sample_ff));

   assign dx_full  = {sample_ff[DATA_W-1], sample_ff} - {tbl_rx[DATA_W-1], tbl_rx};
   assign den_full = {hi_x_ff[DATA_W-1], hi_x_ff} - {tbl_rx[DATA_W-1], tbl_rx};
   assign dy_full  = {hi_y_ff[DATA_W-1], hi_y_ff} - {tbl_ry[DATA_W-1], tbl_ry};
   assign dy_abs   = dy_full[DATA_W] ? (~dy_full + 1'b1) : dy_full;

   assign product  = dx_ff * dy_mag_ff;
   assign q_signed = neg_ff ? (~{1'b0, div_quo[DATA_W-1:0]} + 1'b1)
                            : {1'b0, div_quo[DATA_W-1:0]};
   assign sum_full = {lo_y_ff[DATA_W-1], lo_y_ff} + q_signed;

   assign tbl_wr.en   = req_xfer && (req_bus.command == CMD_LOAD)
                        && (int'(req_bus.point_index) < TABLE_POINTS);
   assign tbl_wr.addr = IDX_W'(req_bus.point_index);
   assign tbl_wr.x    = req_bus.breakpoint_x;
   assign tbl_wr.y    = req_bus.breakpoint_y;
   assign tbl_raddr   = (state_ff == ST_SCAN) ? IDX_W'(rd_idx_ff + 1'b1) : '0;

   assign div_ctrl.start = (state_ff == ST_MULT);

   always_comb begin
      state_in     = state_ff;
      points_in    = csr_wr ? pwdata[POINTS_W-1:0] : points_ff;
      rd_idx_in    = rd_idx_ff;
      last_in      = last_ff;
      sample_in    = sample_ff;
      hi_x_in      = hi_x_ff;
      hi_y_in      = hi_y_ff;
      lo_y_in      = lo_y_ff;
      dx_in        = dx_ff;
      dy_mag_in    = dy_mag_ff;
      neg_in       = neg_ff;
      den_in       = den_ff;
      seg_in       = seg_ff;
      hit_in       = hit_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in = rsp_value_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_seg_in   = rsp_seg_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_bus.command == CMD_EVAL)) begin
               sample_in = req_bus.sample;
               last_in   = IDX_W'(active_n - CNT_W'(1));
               rd_idx_in = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (seg_match) begin
               lo_y_in   = tbl_ry;
               dx_in     = dx_full[DATA_W-1:0];
               den_in    = den_full[DATA_W-1:0];
               dy_mag_in = dy_abs[DATA_W-1:0];
               neg_in    = dy_full[DATA_W];
               seg_in    = rd_idx_ff;
               hit_in    = 1'b1;
               state_in  = ST_MULT;
            end else if (rd_idx_ff == last_ff) begin
               value_in = tbl_ry;
               seg_in   = '0;
               hit_in   = 1'b0;
               state_in = ST_FINISH;
            end else begin
               hi_x_in   = tbl_rx;
               hi_y_in   = tbl_ry;
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
         ST_MULT: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               value_in = sum_full[DATA_W-1:0];
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = value_ff;
               rsp_hit_in   = hit_ff;
               rsp_seg_in   = SEG_W'(seg_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         points_ff    <= POINTS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         points_ff    <= points_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff    <= rd_idx_in;
      last_ff      <= last_in;
      sample_ff    <= sample_in;
      hi_x_ff      <= hi_x_in;
      hi_y_ff      <= hi_y_in;
      lo_y_ff      <= lo_y_in;
      dx_ff        <= dx_in;
      dy_mag_ff    <= dy_mag_in;
      neg_ff       <= neg_in;
      den_ff       <= den_in;
      seg_ff       <= seg_in;
      hit_ff       <= hit_in;
      value_ff     <= value_in;
      rsp_value_ff <= rsp_value_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_seg_ff   <= rsp_seg_in;
   end

   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.result_value  = rsp_value_ff;
   assign rsp_bus.in_segment    = rsp_hit_ff;
   assign rsp_bus.segment_found = rsp_seg_ff;

   assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (rd_idx_ff <= last_ff))
      else $error("scan ran past the last point in use");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_hit_ff == (rsp_seg_ff != '0)))
      else $error("segment index disagrees with hit flag");

   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished result not moved to output register");

endmodule

// ===== rtl/plin_table.sv =====
// plin_table: breakpoint memory, one write port and one registered read port
// depends on plin_pkg
module plin_table
   import plin_pkg::*;
(
   input  logic              clock,
   input  table_wr_type      wr,
   input  logic [IDX_W-1:0]  raddr,
   output logic [DATA_W-1:0] rx,
   output logic [DATA_W-1:0] ry
);

   logic [DATA_W-1:0] x_mem [TABLE_POINTS];
   logic [DATA_W-1:0] y_mem [TABLE_POINTS];
   logic [DATA_W-1:0] rx_ff;
   logic [DATA_W-1:0] ry_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         x_mem[wr.addr] <= wr.x;
         y_mem[wr.addr] <= wr.y;
      end
      rx_ff <= x_mem[raddr];
      ry_ff <= y_mem[raddr];
   end

   assign rx = rx_ff;
   assign ry = ry_ff;

endmodule

// ===== rtl/plin_div.sv =====
// plin_div: restoring divider, one quotient bit per cycle
// depends on plin_pkg
module plin_div
   import plin_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_ctrl_type      ctrl,
   input  logic [PROD_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output div_stat_type      stat,
   output logic [PROD_W-1:0] quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   diff;
   logic              ge;

   assign shifted = {rem_ff, quo_ff[PROD_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
         quo_in = {quo_ff[PROD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule
